// File: rtl/core/ktc_pkg.sv
// ----------------------------------------------------------------------------
// ktc_pkg: shared types and constants of the keyed table
// Transaction payloads, operation and status codes, table sizing and the
// request bundle that drives the table memory.
// ----------------------------------------------------------------------------
package ktc_pkg;

  // Table sizing. Field widths of the transactions are fixed; the table
  // geometry follows from CAPACITY.
  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ENTRY_W   = KEY_W + VAL_W;
  localparam int OPC_W     = 3;
  localparam int STAT_W    = 2;
  localparam int HIT_W     = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_UPDATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [KEY_W-1:0] item_key;
    logic signed [VAL_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value_out;
    logic [HIT_W-1:0]        hit_index;
    logic [CNT_OUT_W-1:0]    entry_count;
  } out_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } ram_req_t;

endpackage

// File: rtl/core/ktc_ram.sv
// ----------------------------------------------------------------------------
// ktc_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ktc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// File: rtl/core/ktc_ctrl.sv
// ----------------------------------------------------------------------------
// ktc_ctrl: operation sequencer of the keyed table
// Walks the table one entry per cycle through the memory read port, with a
// single key comparator, and compacts the table after a delete.
// ----------------------------------------------------------------------------
module ktc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  ktc_pkg::in_t                    req_i,
  output logic                            busy_o,
  output ktc_pkg::ram_req_t               ram_req_o,
  input  logic [ktc_pkg::ENTRY_W-1:0]     rd_data_i,
  output logic                            res_valid_o,
  output ktc_pkg::out_t                   res_o,
  input  logic                            res_take_i
);
  import ktc_pkg::*;

  state_e             state_q, state_d;
  logic [OPC_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  out_t               res_q, res_d;

  logic [CNT_W-1:0]   src;
  logic               scan_issue;
  logic               shift_issue;
  logic               match;
  logic               full;

  // The shared comparator looks at the entry read in the previous cycle.
  assign src         = idx_q + CNT_W'(1);
  assign scan_issue  = (idx_q < fill_q);
  assign shift_issue = (src < fill_q);
  assign match       = cmp_vld_q && (rd_data_i[ENTRY_W-1 -: KEY_W] == key_q);
  assign full        = (fill_q >= CNT_W'(CAPACITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

  // Next state and datapath registers.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    fill_d    = fill_q;
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d              = req_i.opcode;
          key_d             = req_i.item_key;
          val_d             = req_i.item_value;
          idx_d             = '0;
          cmp_vld_d         = 1'b0;
          res_d             = '0;
          res_d.entry_count = CNT_OUT_W'(fill_q);
          state_d           = S_FINISH;
          unique case (req_i.opcode)
            OP_APPEND: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.hit_index   = HIT_W'(fill_q);
                fill_d            = fill_q + CNT_W'(1);
                res_d.entry_count = CNT_OUT_W'(fill_q + CNT_W'(1));
              end
            end
            OP_UPDATE, OP_DELETE, OP_LOOKUP: begin
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              fill_d            = '0;
              res_d.entry_count = '0;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmp_vld_d = scan_issue;
        cmp_idx_d = idx_q[IDX_W-1:0];
        if (scan_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (match) begin
          res_d.hit_index = HIT_W'(cmp_idx_q);
          if (op_q == OP_LOOKUP) begin
            res_d.value_out = rd_data_i[VAL_W-1:0];
            state_d         = S_FINISH;
          end else if (op_q == OP_UPDATE) begin
            state_d = S_FINISH;
          end else begin
            // Delete: move every later entry down by one place.
            idx_d     = CNT_W'(cmp_idx_q);
            cmp_vld_d = 1'b0;
            state_d   = S_SHIFT;
          end
        end else if (!cmp_vld_q && !scan_issue) begin
          res_d.status = ST_MISSING;
          state_d      = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmp_vld_d = shift_issue;
        cmp_idx_d = idx_q[IDX_W-1:0];
        if (shift_issue) begin
          idx_d = src;
        end
        if (!shift_issue && !cmp_vld_q) begin
          fill_d            = fill_q - CNT_W'(1);
          res_d.entry_count = CNT_OUT_W'(fill_q - CNT_W'(1));
          state_d           = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    ram_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && (req_i.opcode == OP_APPEND) && !full) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = fill_q[IDX_W-1:0];
          ram_req_o.wr_data = {req_i.item_key, req_i.item_value};
        end
      end
      S_SCAN: begin
        ram_req_o.rd_en   = scan_issue;
        ram_req_o.rd_addr = idx_q[IDX_W-1:0];
        if (match && (op_q == OP_UPDATE)) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = cmp_idx_q;
          ram_req_o.wr_data = {key_q, val_q};
        end
      end
      S_SHIFT: begin
        ram_req_o.rd_en   = shift_issue;
        ram_req_o.rd_addr = src[IDX_W-1:0];
        if (cmp_vld_q) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = cmp_idx_q;
          ram_req_o.wr_data = rd_data_i;
        end
      end
      S_FINISH: begin
        ram_req_o = '0;
      end
      default: begin
        ram_req_o = '0;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o       = res_q;

endmodule

// File: rtl/core/keyed_table_with_compaction.sv
// ----------------------------------------------------------------------------
// keyed_table_with_compaction: packed key/value table with linear search
// Top level: transaction handshakes, table memory and result register.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY key/value pairs packed at positions
// 0 to count-1 in arrival order and performs one operation per input
// transaction: append, update, delete, look up or clear. It works on one
// transaction at a time. Append, clear and unknown opcodes set their result
// at the edge that accepts the transaction, without a scan. Update and look up
// read the table one entry per cycle through the single read port of the
// table memory, up to the first match or to the end of the table on a miss.
// Delete scans up to the match and then compacts the entries above it, one
// entry per cycle. The input is stalled until the result has been loaded
// into the output register, and the next transaction can be accepted after
// that. A finished result sits in an output register, so the next
// transaction is accepted while the previous result waits to be taken. Keys
// compare as raw 32-bit patterns; duplicates are allowed and only the lowest
// match is acted upon.
module keyed_table_with_compaction (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ktc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ktc_pkg::out_t out_data_o
);
  import ktc_pkg::*;

  logic               busy;
  logic               start;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_valid;
  out_t               res;
  logic               res_take;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;

  // A transaction is taken whenever the sequencer is idle; the output
  // register may still be holding the previous result.
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  ktc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (in_data_i),
    .busy_o      (busy),
    .ram_req_o   (ram_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // The table memory holds the key in the upper half of each word.
  ktc_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (rd_data)
  );

  // The result moves into the output register when that register is empty
  // or is being emptied in this cycle.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted transaction leaves the sequencer busy, so the input stalls once it is taken.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("input not stalled after an accepted transaction");

  // A finished result is held by the sequencer until the output takes it.
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result lost before reaching the output register");

  // A refused append only happens on a full table and points nowhere.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_FULL)) |->
      ((out_data_o.entry_count == CNT_OUT_W'(CAPACITY)) &&
       (out_data_o.hit_index == '0)))
    else $error("full status with a table that is not full");

  // The entry count never exceeds the table size.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.entry_count <= CNT_OUT_W'(CAPACITY)))
    else $error("entry count beyond table capacity");

endmodule
